@@ hdl/skm_pkg.sv @@
// ---------------------------------------------------------------------------
// skm_pkg
// Shared types, codes and constants for the sorted key multimap.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package skm_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int CNT_W        = 7;
    localparam int KEY_W        = 32;
    localparam int VAL_W        = 32;
    localparam int IDX_W        = 6;
    localparam int ST_W         = 2;

    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL = 2'd1;
    localparam logic [ST_W-1:0] ST_MISS = 2'd2;

    typedef enum logic [2:0] {
        ACT_INSERT    = 3'd0,
        ACT_RM_PAIR   = 3'd1,
        ACT_RM_ALL    = 3'd2,
        ACT_LOOKUP    = 3'd3,
        ACT_RM_AT     = 3'd4
    } act_t;

    typedef enum logic [0:0] {
        RD_PTR_DEC,
        RD_PTR_RUN
    } rd_src_t;

    typedef enum logic [2:0] {
        P_HOLD,
        P_INC,
        P_DEC,
        P_ZERO,
        P_CNT,
        P_IDX,
        P_ADD_RUN
    } ptr_op_t;

    typedef enum logic [1:0] {
        R_HOLD,
        R_ZERO,
        R_INC,
        R_ONE
    } run_op_t;

    typedef enum logic [1:0] {
        W_NONE,
        W_MOVE,
        W_NEW
    } wr_op_t;

    typedef enum logic [1:0] {
        C_HOLD,
        C_INC,
        C_SUB
    } cnt_op_t;

    typedef struct packed {
        logic            load;
        logic            rd_en;
        rd_src_t         rd_src;
        ptr_op_t         ptr_op;
        run_op_t         run_op;
        wr_op_t          wr_op;
        cnt_op_t         cnt_op;
        logic            pend_load;
        logic            emit;
        logic [ST_W-1:0] emit_status;
        logic            emit_val;
        logic            emit_rem;
        logic            emit_last;
    } cmd_t;

    typedef struct packed {
        logic [2:0] action;
        logic       full;
        logic       idx_bad;
        logic       ptr_zero;
        logic       pos_end;
        logic       run_zero;
        logic       key_lt;
        logic       key_eq;
        logic       val_eq;
    } stat_t;

endpackage

@@ hdl/skm_datapath.sv @@
// ---------------------------------------------------------------------------
// skm_datapath
// Entry storage, scan pointers, compares and the registered result stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module skm_datapath #(
    parameter int CAPACITY = skm_pkg::CAPACITY_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  skm_pkg::cmd_t                 cmd,
    output skm_pkg::stat_t                stat,
    input  logic [2:0]                    action,
    input  logic signed [skm_pkg::KEY_W-1:0] key,
    input  logic [skm_pkg::VAL_W-1:0]     value,
    input  logic [skm_pkg::IDX_W-1:0]     index,
    output logic                          strobe,
    output logic [skm_pkg::ST_W-1:0]      status,
    output logic [skm_pkg::VAL_W-1:0]     found_value,
    output logic [skm_pkg::CNT_W-1:0]     removed_count,
    output logic [skm_pkg::CNT_W-1:0]     entry_count,
    output logic                          last
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [skm_pkg::CNT_W-1:0] CAP_C = skm_pkg::CNT_W'(CAPACITY);

    logic signed [skm_pkg::KEY_W-1:0] key_mem [CAPACITY];
    logic [skm_pkg::VAL_W-1:0]        val_mem [CAPACITY];

    logic [2:0]                       act_reg;
    logic signed [skm_pkg::KEY_W-1:0] key_reg;
    logic [skm_pkg::VAL_W-1:0]        val_reg;
    logic [skm_pkg::IDX_W-1:0]        idx_reg;
    logic [skm_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic [skm_pkg::CNT_W-1:0]        ptr_reg, ptr_next;
    logic [skm_pkg::CNT_W-1:0]        run_reg, run_next;
    logic [skm_pkg::VAL_W-1:0]        pend_reg;
    logic signed [skm_pkg::KEY_W-1:0] rkey_reg;
    logic [skm_pkg::VAL_W-1:0]        rval_reg;

    logic                             strobe_reg;
    logic [skm_pkg::ST_W-1:0]         status_reg;
    logic [skm_pkg::VAL_W-1:0]        fval_reg;
    logic [skm_pkg::CNT_W-1:0]        rem_reg;
    logic [skm_pkg::CNT_W-1:0]        ecnt_reg;
    logic                             last_reg;

    logic [skm_pkg::CNT_W:0]          pos;
    logic [skm_pkg::CNT_W-1:0]        ptr_dec;
    logic [AW-1:0]                    raddr;
    logic [AW-1:0]                    waddr;

    assign pos     = {1'b0, ptr_reg} + {1'b0, run_reg};
    assign ptr_dec = ptr_reg - 1'b1;
    assign raddr   = (cmd.rd_src == skm_pkg::RD_PTR_DEC) ? ptr_dec[AW-1:0] : pos[AW-1:0];
    assign waddr   = ptr_reg[AW-1:0];

    always_comb
    begin
        stat.action   = act_reg;
        stat.full     = (cnt_reg >= CAP_C);
        stat.idx_bad  = ({1'b0, idx_reg} >= cnt_reg);
        stat.ptr_zero = (ptr_reg == '0);
        stat.pos_end  = (pos >= {1'b0, cnt_reg});
        stat.run_zero = (run_reg == '0);
        stat.key_lt   = (rkey_reg < key_reg);
        stat.key_eq   = (rkey_reg == key_reg);
        stat.val_eq   = (rval_reg == val_reg);
    end

    always_comb
    begin
        ptr_next = ptr_reg;
        unique case (cmd.ptr_op)
            skm_pkg::P_HOLD:    ptr_next = ptr_reg;
            skm_pkg::P_INC:     ptr_next = ptr_reg + 1'b1;
            skm_pkg::P_DEC:     ptr_next = ptr_dec;
            skm_pkg::P_ZERO:    ptr_next = '0;
            skm_pkg::P_CNT:     ptr_next = cnt_reg;
            skm_pkg::P_IDX:     ptr_next = {1'b0, idx_reg};
            skm_pkg::P_ADD_RUN: ptr_next = pos[skm_pkg::CNT_W-1:0];
            default:            ptr_next = ptr_reg;
        endcase
        run_next = run_reg;
        unique case (cmd.run_op)
            skm_pkg::R_HOLD: run_next = run_reg;
            skm_pkg::R_ZERO: run_next = '0;
            skm_pkg::R_INC:  run_next = run_reg + 1'b1;
            skm_pkg::R_ONE:  run_next = skm_pkg::CNT_W'(1);
            default:         run_next = run_reg;
        endcase
        cnt_next = cnt_reg;
        unique case (cmd.cnt_op)
            skm_pkg::C_HOLD: cnt_next = cnt_reg;
            skm_pkg::C_INC:  cnt_next = cnt_reg + 1'b1;
            skm_pkg::C_SUB:  cnt_next = cnt_reg - run_reg;
            default:         cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            ptr_reg    <= '0;
            run_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            ptr_reg    <= ptr_next;
            run_reg    <= run_next;
            strobe_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg <= action;
            key_reg <= key;
            val_reg <= value;
            idx_reg <= index;
        end
        if (cmd.pend_load)
            pend_reg <= rval_reg;
        if (cmd.rd_en)
        begin
            rkey_reg <= key_mem[raddr];
            rval_reg <= val_mem[raddr];
        end
        if (cmd.wr_op == skm_pkg::W_MOVE)
        begin
            key_mem[waddr] <= rkey_reg;
            val_mem[waddr] <= rval_reg;
        end
        else if (cmd.wr_op == skm_pkg::W_NEW)
        begin
            key_mem[waddr] <= key_reg;
            val_mem[waddr] <= val_reg;
        end
        if (cmd.emit)
        begin
            status_reg <= cmd.emit_status;
            fval_reg   <= cmd.emit_val ? pend_reg : '0;
            rem_reg    <= cmd.emit_rem ? run_reg : '0;
            ecnt_reg   <= cnt_next;
            last_reg   <= cmd.emit_last;
        end
    end

    assign strobe        = strobe_reg;
    assign status        = status_reg;
    assign found_value   = fval_reg;
    assign removed_count = rem_reg;
    assign entry_count   = ecnt_reg;
    assign last          = last_reg;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CAP_C)
        else $error("entry count past capacity");
    a_wr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_op != skm_pkg::W_NONE |-> ptr_reg < CAP_C)
        else $error("write past capacity");
    a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && status_reg == skm_pkg::ST_FULL |-> ecnt_reg == CAP_C)
        else $error("full reported below capacity");
    a_sub_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_op == skm_pkg::C_SUB |-> run_reg <= cnt_reg)
        else $error("removal larger than count");
`endif

endmodule

@@ hdl/skm_ctrl.sv @@
// ---------------------------------------------------------------------------
// skm_ctrl
// Sequencer for insert, removal and lookup transactions.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module skm_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  skm_pkg::stat_t stat,
    output skm_pkg::cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_INS_CHK,
        S_INS_EV,
        S_INS_NEW,
        S_SCAN_RD,
        S_SCAN_EV,
        S_SCAN_END,
        S_DROP_CHK,
        S_DROP_WR,
        S_DROP_FIN
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.rd_src      = skm_pkg::RD_PTR_RUN;
        cmd.ptr_op      = skm_pkg::P_HOLD;
        cmd.run_op      = skm_pkg::R_HOLD;
        cmd.wr_op       = skm_pkg::W_NONE;
        cmd.cnt_op      = skm_pkg::C_HOLD;
        cmd.emit_status = skm_pkg::ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.action)
                    skm_pkg::ACT_INSERT:
                    begin
                        if (stat.full)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = skm_pkg::ST_FULL;
                            cmd.emit_last   = 1'b1;
                            state_next      = S_IDLE;
                        end
                        else
                        begin
                            cmd.ptr_op = skm_pkg::P_CNT;
                            state_next = S_INS_CHK;
                        end
                    end
                    skm_pkg::ACT_RM_PAIR, skm_pkg::ACT_RM_ALL, skm_pkg::ACT_LOOKUP:
                    begin
                        cmd.ptr_op = skm_pkg::P_ZERO;
                        cmd.run_op = skm_pkg::R_ZERO;
                        state_next = S_SCAN_RD;
                    end
                    skm_pkg::ACT_RM_AT:
                    begin
                        if (stat.idx_bad)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = skm_pkg::ST_MISS;
                            cmd.emit_last   = 1'b1;
                            state_next      = S_IDLE;
                        end
                        else
                        begin
                            cmd.ptr_op = skm_pkg::P_IDX;
                            cmd.run_op = skm_pkg::R_ONE;
                            state_next = S_DROP_CHK;
                        end
                    end
                    default:
                    begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = skm_pkg::ST_MISS;
                        cmd.emit_last   = 1'b1;
                        state_next      = S_IDLE;
                    end
                endcase
            end
            S_INS_CHK:
            begin
                if (stat.ptr_zero)
                    state_next = S_INS_NEW;
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_src = skm_pkg::RD_PTR_DEC;
                    state_next = S_INS_EV;
                end
            end
            S_INS_EV:
            begin
                if (!stat.key_lt && !stat.key_eq)
                begin
                    cmd.wr_op  = skm_pkg::W_MOVE;
                    cmd.ptr_op = skm_pkg::P_DEC;
                    state_next = S_INS_CHK;
                end
                else
                    state_next = S_INS_NEW;
            end
            S_INS_NEW:
            begin
                cmd.wr_op     = skm_pkg::W_NEW;
                cmd.cnt_op    = skm_pkg::C_INC;
                cmd.emit      = 1'b1;
                cmd.emit_last = 1'b1;
                state_next    = S_IDLE;
            end
            S_SCAN_RD:
            begin
                if (stat.pos_end)
                    state_next = S_SCAN_END;
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_SCAN_EV;
                end
            end
            S_SCAN_EV:
            begin
                if (stat.run_zero && stat.key_lt)
                begin
                    cmd.ptr_op = skm_pkg::P_INC;
                    state_next = S_SCAN_RD;
                end
                else if (stat.key_eq)
                begin
                    if (stat.action == skm_pkg::ACT_RM_PAIR && stat.val_eq)
                    begin
                        cmd.ptr_op = skm_pkg::P_ADD_RUN;
                        cmd.run_op = skm_pkg::R_ONE;
                        state_next = S_DROP_CHK;
                    end
                    else
                    begin
                        if (stat.action == skm_pkg::ACT_LOOKUP)
                        begin
                            cmd.emit      = !stat.run_zero;
                            cmd.emit_val  = 1'b1;
                            cmd.pend_load = 1'b1;
                        end
                        cmd.run_op = skm_pkg::R_INC;
                        state_next = S_SCAN_RD;
                    end
                end
                else
                    state_next = S_SCAN_END;
            end
            S_SCAN_END:
            begin
                if (stat.action == skm_pkg::ACT_RM_ALL && !stat.run_zero)
                    state_next = S_DROP_CHK;
                else
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    if (stat.action == skm_pkg::ACT_LOOKUP && !stat.run_zero)
                        cmd.emit_val = 1'b1;
                    else
                        cmd.emit_status = skm_pkg::ST_MISS;
                    state_next = S_IDLE;
                end
            end
            S_DROP_CHK:
            begin
                if (stat.pos_end)
                    state_next = S_DROP_FIN;
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_DROP_WR;
                end
            end
            S_DROP_WR:
            begin
                cmd.wr_op  = skm_pkg::W_MOVE;
                cmd.ptr_op = skm_pkg::P_INC;
                state_next = S_DROP_CHK;
            end
            S_DROP_FIN:
            begin
                cmd.cnt_op    = skm_pkg::C_SUB;
                cmd.emit      = 1'b1;
                cmd.emit_rem  = 1'b1;
                cmd.emit_last = 1'b1;
                state_next    = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);

`ifndef SYNTHESIS
    a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> busy)
        else $error("result emitted while idle");
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && cmd.emit_last |=> !busy)
        else $error("final result without return to idle");
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !busy && start)
        else $error("capture outside accept");
`endif

endmodule

@@ hdl/sorted_key_multimap.sv @@
// A full-table insert, a bad index or an unknown action is answered from the dispatch state
// without a walk of the table; other actions walk the table and may then shift entries;
// lookup gives one result per matching entry.
// Throughput: one transaction at a time; busy stays high until the final result is issued,
// set by the entry memory read and shift loop, which reads and moves one entry at a time.
// Reset: rst_n clears the entry count and controller; stored entries are not cleared.
// Results are strobed for one cycle and cannot be stalled by the receiver.
// ---------------------------------------------------------------------------
// sorted_key_multimap
// Sorted key/value table with duplicate keys: insert, remove and lookup.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_key_multimap #(
    parameter int CAPACITY = skm_pkg::CAPACITY_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [2:0]                       action,
    input  logic signed [skm_pkg::KEY_W-1:0] key,
    input  logic [skm_pkg::VAL_W-1:0]        value,
    input  logic [skm_pkg::IDX_W-1:0]        index,
    output logic                             strobe,
    output logic [skm_pkg::ST_W-1:0]         status,
    output logic [skm_pkg::VAL_W-1:0]        found_value,
    output logic [skm_pkg::CNT_W-1:0]        removed_count,
    output logic [skm_pkg::CNT_W-1:0]        entry_count,
    output logic                             last
);

    skm_pkg::cmd_t  cmd;
    skm_pkg::stat_t stat;

    skm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    skm_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .action        (action),
        .key           (key),
        .value         (value),
        .index         (index),
        .strobe        (strobe),
        .status        (status),
        .found_value   (found_value),
        .removed_count (removed_count),
        .entry_count   (entry_count),
        .last          (last)
    );

endmodule
